// ===== rtl/ahci_rcb_pkg.sv =====
// ----------------------------------------------------------------------------
// AHCI read command builder package
// Request and record types, record codes and fixed constants.
// ----------------------------------------------------------------------------
package ahci_rcb_pkg;

	localparam logic [31:0] TABLE_BASE_RESET = 32'h0010_C000;
	localparam int unsigned TABLE_SHIFT = 8;
	localparam int unsigned SECTOR_SHIFT = 9;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_FIS    = 2'd1,
		KIND_ENTRY  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_NO_SLOT = 2'd1,
		ERR_RANGE   = 2'd2
	} err_t;

	typedef struct packed {
		logic [47:0] start_lba;
		logic [15:0] sector_total;
		logic [63:0] buffer_address;
		logic [31:0] busy_slots;
	} req_t;

	typedef struct packed {
		kind_t       record_kind;
		logic [4:0]  slot;
		logic [3:0]  entry_count;
		logic [2:0]  entry_index;
		logic [63:0] address;
		logic [12:0] byte_count_m1;
		logic [47:0] lba_out;
		logic [15:0] count_out;
		err_t        error_code;
		logic        last;
	} rec_t;

	typedef struct packed {
		err_t       err;
		logic [4:0] slot;
	} dec_t;

endpackage

// ===== rtl/ahci_read_command_builder.sv =====
// ----------------------------------------------------------------------------
// AHCI read command builder
// Turns a READ DMA EXT request into a command header, a register FIS and
// the descriptor entries, or into one error record.
//
//   Channel   Handshake                Payload
//   request   req_valid / req_ready    req (req_t)
//   record    rec_valid / rec_ready    rec (rec_t)
//   config    cfg_write                cfg_data (table base)
//
// One record leaves per cycle while rec_ready is high; a request gives a
// header, a FIS and its entries, an error request one error record.
// The next request is taken in the cycle its predecessor's last record
// enters the output register. The output register holds a record while
// rec_ready is low. Reset loads the table base reset value and empties
// both stages.
// ----------------------------------------------------------------------------
module ahci_read_command_builder #(
	parameter int MAX_ENTRIES       = 8,
	parameter int SECTORS_PER_ENTRY = 16,
	parameter int SLOT_COUNT        = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ahci_rcb_pkg::req_t   req,
	output logic                 rec_valid,
	input  logic                 rec_ready,
	output ahci_rcb_pkg::rec_t   rec,
	input  logic                 cfg_write,
	input  logic [31:0]          cfg_data
);
	import ahci_rcb_pkg::*;

	localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);

	logic [31:0]        table_base_q;
	dec_t               dec;
	logic [ENTRY_W-1:0] entries;
	logic               load;
	logic               advance;
	logic               busy;
	rec_t               cur;
	logic               rec_valid_q;
	rec_t               rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= TABLE_BASE_RESET;
		end else if (cfg_write) begin
			table_base_q <= cfg_data;
		end
	end

	ahci_rcb_decode #(
		.MAX_ENTRIES       (MAX_ENTRIES),
		.SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
		.SLOT_COUNT        (SLOT_COUNT),
		.ENTRY_W           (ENTRY_W)
	) u_decode (
		.req     (req),
		.dec     (dec),
		.entries (entries)
	);

	ahci_rcb_seq #(
		.MAX_ENTRIES       (MAX_ENTRIES),
		.SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
		.ENTRY_W           (ENTRY_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.req        (req),
		.dec        (dec),
		.entries    (entries),
		.table_base (table_base_q),
		.advance    (advance),
		.busy       (busy),
		.cur        (cur)
	);

	assign advance   = busy && (!rec_valid_q || rec_ready);
	assign req_ready = !busy || (advance && cur.last);
	assign load      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (advance) begin
			rec_valid_q <= 1'b1;
		end else if (rec_ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_q <= cur;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy)
		else $error("accepted request did not occupy the sequencer");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cur.last) |=> busy)
		else $error("record run ended before its last record");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec.record_kind == KIND_ERROR) |->
		(rec.last && rec.error_code != ERR_NONE))
		else $error("error record without last flag or code");

endmodule

// ===== rtl/ahci_rcb_decode.sv =====
// ----------------------------------------------------------------------------
// AHCI read command builder request decode
// Picks the lowest free slot, checks the sector count and works out the
// number of descriptor entries with a reciprocal multiply.
// ----------------------------------------------------------------------------
module ahci_rcb_decode #(
	parameter int MAX_ENTRIES       = 8,
	parameter int SECTORS_PER_ENTRY = 16,
	parameter int SLOT_COUNT        = 32,
	parameter int ENTRY_W           = $clog2(MAX_ENTRIES + 1)
) (
	input  ahci_rcb_pkg::req_t       req,
	output ahci_rcb_pkg::dec_t       dec,
	output logic [ENTRY_W-1:0]       entries
);
	import ahci_rcb_pkg::*;

	localparam int NUM_W = 17;
	localparam int SH = NUM_W + $clog2(SECTORS_PER_ENTRY);
	localparam int RECIP_W = NUM_W + 2;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(SECTORS_PER_ENTRY) - 64'd1) / 64'(SECTORS_PER_ENTRY);
	localparam longint unsigned CAP =
		64'(MAX_ENTRIES) * 64'(SECTORS_PER_ENTRY);

	logic                     found;
	logic [4:0]               slot_c;
	logic [NUM_W-1:0]         num;
	logic [NUM_W+RECIP_W-1:0] prod;

	always_comb begin
		found  = 1'b0;
		slot_c = 5'd0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!req.busy_slots[i]) begin
				found  = 1'b1;
				slot_c = 5'(i);
			end
		end
	end

	always_comb begin
		dec.slot = 5'd0;
		dec.err  = ERR_NONE;
		if (!found) begin
			dec.err = ERR_NO_SLOT;
		end else if (req.sector_total == 16'd0 || 64'(req.sector_total) > CAP) begin
			dec.err = ERR_RANGE;
		end else begin
			dec.slot = slot_c;
		end
	end

	assign num     = NUM_W'(req.sector_total) + NUM_W'(SECTORS_PER_ENTRY - 1);
	assign prod    = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(RECIP);
	assign entries = ENTRY_W'(prod >> SH);

endmodule

// ===== rtl/ahci_rcb_seq.sv =====
// ----------------------------------------------------------------------------
// AHCI read command builder record sequencer
// Holds one decoded request and forms its header, FIS and descriptor
// records one at a time, or its single error record.
// ----------------------------------------------------------------------------
module ahci_rcb_seq #(
	parameter int MAX_ENTRIES       = 8,
	parameter int SECTORS_PER_ENTRY = 16,
	parameter int ENTRY_W           = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ahci_rcb_pkg::req_t   req,
	input  ahci_rcb_pkg::dec_t   dec,
	input  logic [ENTRY_W-1:0]   entries,
	input  logic [31:0]          table_base,
	input  logic                 advance,
	output logic                 busy,
	output ahci_rcb_pkg::rec_t   cur
);
	import ahci_rcb_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [63:0] ADDR_STEP = 64'(SECTORS_PER_ENTRY) << SECTOR_SHIFT;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_FIS    = 3'b010,
		PH_ENTRY  = 3'b100
	} phase_t;

	phase_t             phase_s1;
	logic               busy_s1;
	dec_t               dec_s1;
	logic [ENTRY_W-1:0] entries_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [47:0]        lba_s1;
	logic [15:0]        total_s1;
	logic [15:0]        remain_s1;
	logic [63:0]        addr_s1;
	logic               final_entry;
	logic [15:0]        n_sectors;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1  <= 1'b0;
			phase_s1 <= PH_HEADER;
		end else if (load) begin
			busy_s1  <= 1'b1;
			phase_s1 <= PH_HEADER;
		end else if (advance) begin
			if (cur.last) begin
				busy_s1 <= 1'b0;
			end else begin
				case (phase_s1)
					PH_HEADER: phase_s1 <= PH_FIS;
					PH_FIS:    phase_s1 <= PH_ENTRY;
					PH_ENTRY:  phase_s1 <= PH_ENTRY;
					default:   phase_s1 <= PH_HEADER;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_s1     <= dec;
			entries_s1 <= entries;
			idx_s1     <= '0;
			lba_s1     <= req.start_lba;
			total_s1   <= req.sector_total;
			remain_s1  <= req.sector_total;
			addr_s1    <= req.buffer_address;
		end else if (advance && phase_s1 == PH_ENTRY) begin
			idx_s1    <= idx_s1 + IDX_W'(1);
			remain_s1 <= remain_s1 - 16'(SECTORS_PER_ENTRY);
			addr_s1   <= addr_s1 + ADDR_STEP;
		end
	end

	assign final_entry = (ENTRY_W'(idx_s1) + ENTRY_W'(1)) == entries_s1;
	assign n_sectors   = final_entry ? remain_s1 : 16'(SECTORS_PER_ENTRY);

	always_comb begin
		cur = '0;
		if (dec_s1.err != ERR_NONE) begin
			cur.record_kind = KIND_ERROR;
			cur.error_code  = dec_s1.err;
			cur.last        = 1'b1;
		end else begin
			cur.slot = dec_s1.slot;
			case (phase_s1)
				PH_HEADER: begin
					cur.record_kind = KIND_HEADER;
					cur.entry_count = 4'(entries_s1);
					cur.address     = 64'(table_base) + (64'(dec_s1.slot) << TABLE_SHIFT);
				end
				PH_FIS: begin
					cur.record_kind = KIND_FIS;
					cur.lba_out     = lba_s1;
					cur.count_out   = total_s1;
				end
				PH_ENTRY: begin
					cur.record_kind   = KIND_ENTRY;
					cur.entry_index   = 3'(idx_s1);
					cur.address       = addr_s1;
					cur.byte_count_m1 = {n_sectors[3:0], 9'd0} - 13'd1;
					cur.last          = final_entry;
				end
				default: begin
					cur.record_kind = KIND_ERROR;
				end
			endcase
		end
	end

	assign busy = busy_s1;

endmodule

// ===== sim/ahci_read_command_builder_tb.sv =====
// ----------------------------------------------------------------------------
// AHCI read command builder testbench
// Sends READ DMA EXT requests through the valid/ready request channel and
// checks every record against a local model of slot selection, header, FIS
// and descriptor layout. A short table of directed requests comes first,
// then random requests under several table base settings, with random
// idling on both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
module ahci_read_command_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ahci_rcb_pkg::*;

	localparam int MAX_ENTRIES       = 8;
	localparam int SECTORS_PER_ENTRY = 16;
	localparam int SLOT_COUNT        = 32;
	localparam int SECTOR_CAPACITY   = MAX_ENTRIES * SECTORS_PER_ENTRY;
	localparam int PHASE_REQUESTS    = 50;
	localparam int REPORT_LIMIT      = 10;

	typedef struct {
		req_t req;
		err_t known_err;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rec_valid;
	logic        rec_ready = 1'b0;
	rec_t        rec;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = '0;

	rec_t          expected_records[$];
	directed_row_t directed_rows[$];
	logic [31:0]   table_base_model = TABLE_BASE_RESET;
	bit            full_rate = 1'b0;
	int            ready_burst_left = 0;
	int            mismatches = 0;
	int            requests_sent = 0;
	int            records_checked = 0;
	int            error_records = 0;
	int            base_settings = 1;

	ahci_read_command_builder #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.SECTORS_PER_ENTRY(SECTORS_PER_ENTRY),
		.SLOT_COUNT(SLOT_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void build_records(input req_t r);
		int   free_slot;
		int   n_entries;
		int   sectors;
		int   s;
		int   i;
		rec_t x;
		free_slot = -1;
		for (s = 0; s < SLOT_COUNT; s++) begin
			if (!r.busy_slots[s] && free_slot < 0) begin
				free_slot = s;
			end
		end
		x = '0;
		if (free_slot < 0 || r.sector_total == 0 || r.sector_total > SECTOR_CAPACITY) begin
			x.record_kind = KIND_ERROR;
			x.error_code = (free_slot < 0) ? ERR_NO_SLOT : ERR_RANGE;
			x.last = 1'b1;
			expected_records.push_back(x);
			return;
		end
		n_entries = (int'(r.sector_total) + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY;
		x.record_kind = KIND_HEADER;
		x.slot = 5'(free_slot);
		x.entry_count = 4'(n_entries);
		x.address = 64'(table_base_model) + (64'(free_slot) << TABLE_SHIFT);
		expected_records.push_back(x);
		x = '0;
		x.record_kind = KIND_FIS;
		x.slot = 5'(free_slot);
		x.lba_out = r.start_lba;
		x.count_out = r.sector_total;
		expected_records.push_back(x);
		for (i = 0; i < n_entries; i++) begin
			sectors = (i + 1 == n_entries) ? int'(r.sector_total) - i * SECTORS_PER_ENTRY
				: SECTORS_PER_ENTRY;
			x = '0;
			x.record_kind = KIND_ENTRY;
			x.slot = 5'(free_slot);
			x.entry_index = 3'(i);
			x.address = r.buffer_address + (64'(i * SECTORS_PER_ENTRY) << SECTOR_SHIFT);
			x.byte_count_m1 = 13'((sectors << SECTOR_SHIFT) - 1);
			x.last = (i + 1 == n_entries);
			expected_records.push_back(x);
		end
	endfunction

	function automatic void add_row(input logic [47:0] lba, input logic [15:0] total,
			input logic [63:0] buf_addr, input logic [31:0] busy, input err_t known_err);
		directed_row_t row;
		row.req.start_lba = lba;
		row.req.sector_total = total;
		row.req.buffer_address = buf_addr;
		row.req.busy_slots = busy;
		row.known_err = known_err;
		directed_rows.push_back(row);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		r.start_lba = {16'($urandom), $urandom};
		r.buffer_address = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.busy_slots = $urandom;
		end else if (pick < 80) begin
			r.busy_slots = ~(32'd1 << $urandom_range(0, SLOT_COUNT - 1));
		end else if (pick < 92) begin
			r.busy_slots = '0;
		end else begin
			r.busy_slots = '1;
		end
		pick = $urandom_range(0, 99);
		if (pick < 88) begin
			r.sector_total = 16'($urandom_range(1, SECTOR_CAPACITY));
		end else if (pick < 93) begin
			r.sector_total = '0;
		end else begin
			r.sector_total = 16'($urandom_range(SECTOR_CAPACITY + 1, 65535));
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			if (mismatches < REPORT_LIMIT) begin
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			end
			mismatches++;
		end
	endtask

	task automatic check_record(input rec_t got);
		rec_t want;
		if (expected_records.size() == 0) begin
			if (mismatches < REPORT_LIMIT) begin
				$display("%0t: record %h arrived with nothing expected", $realtime, got);
			end
			mismatches++;
			return;
		end
		want = expected_records.pop_front();
		records_checked++;
		if (want.record_kind == KIND_ERROR) begin
			error_records++;
		end
		check_field("record_kind", want.record_kind, got.record_kind);
		check_field("slot", want.slot, got.slot);
		check_field("entry_count", want.entry_count, got.entry_count);
		check_field("entry_index", want.entry_index, got.entry_index);
		check_field("address", want.address, got.address);
		check_field("byte_count_m1", want.byte_count_m1, got.byte_count_m1);
		check_field("lba_out", want.lba_out, got.lba_out);
		check_field("count_out", want.count_out, got.count_out);
		check_field("error_code", want.error_code, got.error_code);
		check_field("last", want.last, got.last);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_valid && rec_ready) begin
				check_record(rec);
			end
			if (full_rate) begin
				rec_ready <= 1'b1;
			end else if (ready_burst_left > 0) begin
				ready_burst_left <= ready_burst_left - 1;
			end else begin
				rec_ready <= ($urandom_range(0, 2) != 0);
				ready_burst_left <= $urandom_range(0, 11);
			end
		end
	end

	task automatic send_request(input req_t r, input err_t known_err);
		rec_t want;
		if (!full_rate && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		requests_sent++;
		if (known_err != ERR_NONE) begin
			want = '0;
			want.record_kind = KIND_ERROR;
			want.error_code = known_err;
			want.last = 1'b1;
			expected_records.push_back(want);
		end else begin
			build_records(r);
		end
	endtask

	task automatic drain_records();
		req_valid <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_table_base(input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		table_base_model = value;
		base_settings++;
	endtask

	task automatic run_random_phase();
		int n;
		for (n = 0; n < PHASE_REQUESTS; n++) begin
			send_request(random_request(), ERR_NONE);
		end
	endtask

	initial begin
		int n;
		add_row(48'h0, 16'd5, 64'h0, 32'hFFFF_FFFF, ERR_NO_SLOT);
		add_row(48'h0, 16'd0, 64'h0, 32'hFFFF_FFFF, ERR_NO_SLOT);
		add_row(48'h0, 16'd0, 64'h0, 32'h0, ERR_RANGE);
		add_row(48'h0, 16'(SECTOR_CAPACITY + 1), 64'h0, 32'h0, ERR_RANGE);
		add_row(48'hFFFF_FFFF_FFFF, 16'hFFFF, 64'h0, 32'h0, ERR_RANGE);
		add_row(48'h0, 16'd1, 64'h0, 32'h0, ERR_NONE);
		add_row(48'h1, 16'd16, 64'h1000, 32'h1, ERR_NONE);
		add_row(48'h12_3456, 16'd17, 64'h8000_0000, 32'h3, ERR_NONE);
		add_row(48'hFFFF_FFFF_FFFF, 16'(SECTOR_CAPACITY), 64'hFFFF_FFFF_FFFF_FFFF,
			32'h0, ERR_NONE);
		add_row(48'hFFFF_FFFF_FFFF, 16'(SECTOR_CAPACITY), 64'hFFFF_FFFF_FFFF_F000,
			32'h7FFF_FFFF, ERR_NONE);
		add_row(48'h0, 16'd64, 64'hFFFF_FFFF_FFFF_C000, 32'hFFFF_FFFE, ERR_NONE);
		add_row(48'hAAAA_AAAA_AAAA, 16'd112, 64'h5555_5555_5555_5555, 32'h0000_FFFF,
			ERR_NONE);
		add_row(48'h5555_5555_5555, 16'd113, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
			ERR_NONE);
		add_row(48'h8000_0000_0000, 16'd127, 64'h8000_0000_0000_0000, 32'hAAAA_AAAA,
			ERR_NONE);
		add_row(48'h0000_FFFF_0000, 16'd15, 64'h0000_0000_FFFF_FFFF, 32'hBFFF_FFFF,
			ERR_NONE);
		add_row(48'h7FFF_FFFF_FFFF, 16'd32, 64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000,
			ERR_NONE);
		add_row(48'h0, 16'd1, 64'h0, 32'hFFFF_FFFF, ERR_NO_SLOT);
		add_row(48'h1234_5678_9ABC, 16'd48, 64'h0123_4567_89AB_CDEF, 32'hFFFF_7FFF,
			ERR_NONE);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < directed_rows.size(); n++) begin
			send_request(directed_rows[n].req, directed_rows[n].known_err);
		end

		drain_records();
		write_table_base(32'h0);
		run_random_phase();

		drain_records();
		write_table_base(32'hFFFF_FFFF);
		run_random_phase();

		drain_records();
		write_table_base($urandom);
		run_random_phase();

		drain_records();
		write_table_base(32'hFFFF_FF00);
		full_rate = 1'b1;
		run_random_phase();

		drain_records();
		repeat (16) @(posedge clk);
		$display("Requests sent: %0d, records checked: %0d, error records: %0d.",
			requests_sent, records_checked, error_records);
		$display("Table base settings used: %0d, mismatches: %0d.", base_settings,
			mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d records still expected.", expected_records.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
